### rtl/hhds_pkg.sv
// ----------------------------------------------------------------------------
// hhds_pkg
// Shared types, constants and helpers for the heading hold steering pipeline.
// ----------------------------------------------------------------------------
package hhds_pkg;

    // Angles in centidegrees
    localparam int FULL_TURN = 36000;
    localparam int HALF_TURN = 18000;

    // Gains in tenths
    localparam logic [3:0] GAIN_UNITY    = 4'd10;
    localparam int         MAX_GAIN_STEP = 4;

    // Reciprocal shift used for the level quantizer
    localparam int QUOT_SHIFT = 16;

    // Divide by ten: (x * 6554) >> 16 is exact for x below 4096
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int          DIV10_SHIFT = 16;

    // Stage payload after the heading error stage
    typedef struct packed {
        logic [14:0]       aerr;      // |error|, at most a half turn
        logic              err_neg;
        logic              err_zero;
        logic signed [8:0] speed;
    } err_t;

    // Stage payload after the quantizer
    typedef struct packed {
        logic signed [6:0] level;     // saturated correction level
        logic [3:0]        left_gain;
        logic [3:0]        right_gain;
        logic signed [8:0] speed;
    } level_t;

    // Reduce a signed 17 bit angle into 0..35999
    function automatic logic [15:0] wrap_ref(input logic signed [16:0] v);
        logic signed [17:0] x;
        logic signed [17:0] r;
        begin
            x = 18'(v);
            if (x >= 18'sd36000)
                r = x - 18'sd36000;
            else if (x >= 18'sd0)
                r = x;
            else if (x >= -18'sd36000)
                r = x + 18'sd36000;
            else
                r = x + 18'sd72000;
            return r[15:0];
        end
    endfunction

endpackage

### rtl/hhds_err.sv
// ----------------------------------------------------------------------------
// hhds_err
// Heading wrap and shortest signed turn from measured heading to reference.
// ----------------------------------------------------------------------------
module hhds_err (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          ref_heading,   // already wrapped to 0..35999
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   heading,
    input  logic signed [8:0]    base_speed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hhds_pkg::err_t       out_data
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  load;
    hhds_pkg::err_t        data_reg;
    hhds_pkg::err_t        data_next;
    logic signed [16:0]    meas;
    logic signed [16:0]    diff;
    logic [16:0]           adiff;
    logic signed [16:0]    err;

    // Stage is free when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Wrap measured heading, take difference, pick the short way round
    always_comb
    begin
        meas = 17'(heading);
        if (heading[15])
            meas = meas + 17'(hhds_pkg::FULL_TURN);
        diff  = $signed({1'b0, ref_heading}) - meas;
        adiff = diff[16] ? 17'(-diff) : 17'(diff);
        if (adiff < 17'(hhds_pkg::HALF_TURN))
            err = diff;
        else if (!diff[16])
            err = diff - 17'(hhds_pkg::FULL_TURN);
        else
            err = diff + 17'(hhds_pkg::FULL_TURN);
        data_next.aerr     = err[16] ? 15'(-err) : 15'(err);
        data_next.err_neg  = err[16];
        data_next.err_zero = (err == 17'sd0);
        data_next.speed    = base_speed;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/hhds_quant.sv
// ----------------------------------------------------------------------------
// hhds_quant
// Two stage error quantizer: reciprocal multiply, then remainder correction,
// level sign, saturation and gain pair lookup.
// ----------------------------------------------------------------------------
module hhds_quant #(
    parameter int LEVEL_STEP = 500
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hhds_pkg::err_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hhds_pkg::level_t   out_data
);

    // Reciprocal of the step; one correction step restores the exact quotient
    localparam int RECIP    = (1 << hhds_pkg::QUOT_SHIFT) / LEVEL_STEP;
    localparam int RW       = $clog2(RECIP + 1);
    localparam int PW       = 15 + RW;
    localparam int QW       = $clog2(hhds_pkg::HALF_TURN / LEVEL_STEP + 2);

    // Stage B registers
    logic                  b_valid_reg;
    logic                  b_valid_next;
    logic [PW-1:0]         b_prod_reg;
    logic [PW-1:0]         b_prod_next;
    hhds_pkg::err_t        b_err_reg;
    logic                  b_ready;
    // Stage C registers
    logic                  c_valid_reg;
    logic                  c_valid_next;
    hhds_pkg::level_t      c_data_reg;
    hhds_pkg::level_t      c_data_next;
    // Stage C logic
    logic [PW-1:0]         shifted;
    logic [QW-1:0]         q0;
    logic [15:0]           qstep;
    logic [15:0]           rem;
    logic [QW-1:0]         mag;
    logic                  lvl_zero;
    logic                  lvl_neg;
    logic [2:0]            k;
    logic [6:0]            mag7;

    // Handshake chain
    assign b_ready  = !c_valid_reg || out_ready;
    assign in_ready = !b_valid_reg || b_ready;

    // Stage B: approximate quotient product
    assign b_prod_next = PW'(in_data.aerr) * PW'(RECIP);

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_ready)
            b_valid_next = in_valid;
        c_valid_next = c_valid_reg;
        if (b_ready)
            c_valid_next = b_valid_reg;
    end

    // Stage C: fix quotient, build signed level and gains
    always_comb
    begin
        shifted  = b_prod_reg >> hhds_pkg::QUOT_SHIFT;
        q0       = QW'(shifted);
        qstep    = 16'(q0 * LEVEL_STEP);
        rem      = {1'b0, b_err_reg.aerr} - qstep;
        mag      = q0 + QW'(1) + QW'(rem >= 16'(LEVEL_STEP));
        lvl_zero = b_err_reg.err_zero || (b_err_reg.speed == 9'sd0);
        lvl_neg  = !lvl_zero && (b_err_reg.err_neg ^ b_err_reg.speed[8]);

        if (lvl_zero)
            k = 3'd0;
        else if (mag >= QW'(hhds_pkg::MAX_GAIN_STEP))
            k = 3'(hhds_pkg::MAX_GAIN_STEP);
        else
            k = 3'(mag);

        // Report range is -64..63
        if (lvl_zero)
            mag7 = 7'd0;
        else if (lvl_neg && (mag > 64))
            mag7 = 7'd64;
        else if (!lvl_neg && (mag > 63))
            mag7 = 7'd63;
        else
            mag7 = 7'(mag);

        c_data_next.level = lvl_neg ? $signed(-mag7) : $signed(mag7);
        if (lvl_neg)
        begin
            c_data_next.left_gain  = hhds_pkg::GAIN_UNITY + 4'(k);
            c_data_next.right_gain = hhds_pkg::GAIN_UNITY - 4'(k);
        end
        else
        begin
            c_data_next.left_gain  = hhds_pkg::GAIN_UNITY - 4'(k);
            c_data_next.right_gain = hhds_pkg::GAIN_UNITY + 4'(k);
        end
        c_data_next.speed = b_err_reg.speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            b_prod_reg <= b_prod_next;
            b_err_reg  <= in_data;
        end
        if (b_valid_reg && b_ready)
            c_data_reg <= c_data_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

    // Gains always stay a balanced pair around unity
    a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (5'(c_data_reg.left_gain) + 5'(c_data_reg.right_gain)) == 5'd20)
        else $error("gain pair does not sum to twenty");

    // No correction means straight drive
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && (c_data_reg.level == 7'sd0)) |->
            (c_data_reg.left_gain == hhds_pkg::GAIN_UNITY))
        else $error("zero level with uneven gains");

endmodule

### rtl/hhds_drive.sv
// ----------------------------------------------------------------------------
// hhds_drive
// Wheel drive scaling: speed times gain, then divide by ten toward zero.
// ----------------------------------------------------------------------------
module hhds_drive (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hhds_pkg::level_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [9:0]    left_drive,
    output logic signed [9:0]    right_drive,
    output logic signed [6:0]    correction_level
);

    // Stage D: magnitude of speed * gain
    logic                  d_valid_reg;
    logic                  d_valid_next;
    logic [11:0]           d_left_abs_reg;
    logic [11:0]           d_right_abs_reg;
    logic                  d_left_neg_reg;
    logic                  d_right_neg_reg;
    logic signed [6:0]     d_level_reg;
    logic                  d_ready;
    logic signed [13:0]    prod_left;
    logic signed [13:0]    prod_right;
    // Stage E: output register
    logic                  e_valid_reg;
    logic                  e_valid_next;
    logic signed [9:0]     e_left_reg;
    logic signed [9:0]     e_left_next;
    logic signed [9:0]     e_right_reg;
    logic signed [9:0]     e_right_next;
    logic signed [6:0]     e_level_reg;
    logic [24:0]           quot_left_w;
    logic [24:0]           quot_right_w;
    logic [8:0]            quot_left;
    logic [8:0]            quot_right;

    assign d_ready  = !e_valid_reg || out_ready;
    assign in_ready = !d_valid_reg || d_ready;

    // Signed products
    assign prod_left  = 14'(in_data.speed) * 14'($signed({1'b0, in_data.left_gain}));
    assign prod_right = 14'(in_data.speed) * 14'($signed({1'b0, in_data.right_gain}));

    // Divide magnitudes by ten, restore sign (truncates toward zero)
    always_comb
    begin
        quot_left_w  = 25'(d_left_abs_reg) * 25'(hhds_pkg::DIV10_RECIP);
        quot_right_w = 25'(d_right_abs_reg) * 25'(hhds_pkg::DIV10_RECIP);
        quot_left    = 9'(quot_left_w >> hhds_pkg::DIV10_SHIFT);
        quot_right   = 9'(quot_right_w >> hhds_pkg::DIV10_SHIFT);
        e_left_next  = d_left_neg_reg ? $signed(-10'(quot_left)) : $signed(10'(quot_left));
        e_right_next = d_right_neg_reg ? $signed(-10'(quot_right))
                                       : $signed(10'(quot_right));
    end

    always_comb
    begin
        d_valid_next = d_valid_reg;
        if (in_ready)
            d_valid_next = in_valid;
        e_valid_next = e_valid_reg;
        if (d_ready)
            e_valid_next = d_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            d_left_abs_reg  <= 12'(prod_left[13] ? -prod_left : prod_left);
            d_right_abs_reg <= 12'(prod_right[13] ? -prod_right : prod_right);
            d_left_neg_reg  <= prod_left[13];
            d_right_neg_reg <= prod_right[13];
            d_level_reg     <= in_data.level;
        end
        if (d_valid_reg && d_ready)
        begin
            e_left_reg  <= e_left_next;
            e_right_reg <= e_right_next;
            e_level_reg <= d_level_reg;
        end
    end

    assign out_valid        = e_valid_reg;
    assign left_drive       = e_left_reg;
    assign right_drive      = e_right_reg;
    assign correction_level = e_level_reg;

    // Equal gains give equal drives
    a_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && (e_level_reg == 7'sd0)) |-> (e_left_reg == e_right_reg))
        else $error("uneven drives without correction");

endmodule

### rtl/heading_hold_differential_steer_top.sv
// ----------------------------------------------------------------------------
// heading_hold_differential_steer_top
// Heading hold for a differential drive: quantized heading error selects a
// left/right gain pair applied to the base speed.
//
//   channel   handshake           payload
//   -------   ---------           -------
//   input     in_valid/in_ready   heading, base_speed
//   output    out_valid/out_ready left_drive, right_drive, correction_level
//   config    cfg_we              cfg_data (reference heading)
//
// One transfer per cycle sustained while the output is ready; the register
// stages are, in order: error, reciprocal product, level/gains, product, divide.
// Each stage holds its item while the next one is full, so a stall on the
// output backs up stage by stage without loss; bubbles are squeezed out.
// Reset clears all stage valid bits and sets the reference heading to zero.
// The reference is wrapped to 0..35999 when written.
// ----------------------------------------------------------------------------
module heading_hold_differential_steer_top #(
    parameter int LEVEL_STEP = 500
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic signed [16:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   heading,
    input  logic signed [8:0]    base_speed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [9:0]    left_drive,
    output logic signed [9:0]    right_drive,
    output logic signed [6:0]    correction_level
);

    logic [15:0]          ref_reg;
    logic [15:0]          ref_next;
    logic                 err_valid;
    logic                 err_ready;
    hhds_pkg::err_t       err_data;
    logic                 lvl_valid;
    logic                 lvl_ready;
    hhds_pkg::level_t     lvl_data;

    // Reference heading register, stored already wrapped
    always_comb
    begin
        ref_next = ref_reg;
        if (cfg_we)
            ref_next = hhds_pkg::wrap_ref(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_reg <= 16'd0;
        else
            ref_reg <= ref_next;
    end

    // Heading error stage
    hhds_err u_err (
        .clk         (clk),
        .rst_n       (rst_n),
        .ref_heading (ref_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .heading     (heading),
        .base_speed  (base_speed),
        .out_valid   (err_valid),
        .out_ready   (err_ready),
        .out_data    (err_data)
    );

    // Level quantizer and gain selection
    hhds_quant #(
        .LEVEL_STEP (LEVEL_STEP)
    ) u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_data  (lvl_data)
    );

    // Wheel drive scaling and output register
    hhds_drive u_drive (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (lvl_valid),
        .in_ready         (lvl_ready),
        .in_data          (lvl_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_drive       (left_drive),
        .right_drive      (right_drive),
        .correction_level (correction_level)
    );

    // Stored reference always lies in one turn
    a_ref_range: assert property (@(posedge clk)
        ref_reg < 16'd36000)
        else $error("reference heading out of range");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heading_hold_differential_steer_top. Each input
// transfer is predicted in-bench (wrapped heading error, quantized level,
// gain pair, drive products) and queued. Each output transfer is checked
// field by field against the oldest queued prediction. Both channels get
// random gaps, and one phase holds the output off long enough to back the
// pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LEVEL_STEP  = 500;
    localparam int LATENCY     = 5;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_LIMIT  = 1000;

    // One predicted result
    typedef struct packed {
        logic signed [9:0] left;
        logic signed [9:0] right;
        logic signed [6:0] level;
    } drive_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic signed [16:0]  cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic signed [15:0]  heading;
    logic signed [8:0]   base_speed;
    logic                out_valid;
    logic                out_ready;
    logic signed [9:0]   left_drive;
    logic signed [9:0]   right_drive;
    logic signed [6:0]   correction_level;

    // Bench copy of the reference register and the expected drive queue
    logic signed [16:0]  ref_mirror = '0;
    drive_t              drive_expq[$];
    int                  fail_count = 0;

    // Idle control shared by the stimulus tasks and the receiver
    int                  tx_gap_pct = 0;
    int                  rx_stall_pct = 0;
    bit                  hold_req = 1'b0;

    heading_hold_differential_steer_top #(
        .LEVEL_STEP (LEVEL_STEP)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .heading          (heading),
        .base_speed       (base_speed),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_drive       (left_drive),
        .right_drive      (right_drive),
        .correction_level (correction_level)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Steering prediction
    // ------------------------------------------------------------------
    function automatic int sgn(input int v);
        if (v > 0)
            return 1;
        else if (v < 0)
            return -1;
        return 0;
    endfunction

    // Map any angle into 0..35999
    function automatic int wrap_turn(input int a);
        int r;
        r = a % hhds_pkg::FULL_TURN;
        if (r < 0)
            r += hhds_pkg::FULL_TURN;
        return r;
    endfunction

    function automatic drive_t steer_predict(input logic signed [15:0] hdg,
                                             input logic signed [8:0]  spd,
                                             input logic signed [16:0] tgt);
        int     meas;
        int     speed;
        int     diff;
        int     adiff;
        int     err;
        int     aerr;
        int     lvl;
        int     k;
        int     lg;
        int     rg;
        int     sat;
        drive_t d;
        meas  = wrap_turn(int'(hdg));
        speed = int'(spd);
        diff  = wrap_turn(int'(tgt)) - meas;
        adiff = (diff < 0) ? -diff : diff;
        // Shortest turn; a half turn takes the wrapped direction
        err   = (adiff < hhds_pkg::HALF_TURN) ? diff
                                              : -sgn(diff) * (hhds_pkg::FULL_TURN - adiff);
        aerr  = (err < 0) ? -err : err;
        lvl   = sgn(err) * ((aerr + LEVEL_STEP) / LEVEL_STEP) * sgn(speed);
        k     = (lvl < 0) ? -lvl : lvl;
        if (k > hhds_pkg::MAX_GAIN_STEP)
            k = hhds_pkg::MAX_GAIN_STEP;
        if (lvl < 0)
        begin
            lg = int'(hhds_pkg::GAIN_UNITY) + k;
            rg = int'(hhds_pkg::GAIN_UNITY) - k;
        end
        else
        begin
            lg = int'(hhds_pkg::GAIN_UNITY) - k;
            rg = int'(hhds_pkg::GAIN_UNITY) + k;
        end
        sat = lvl;
        if (sat > 63)
            sat = 63;
        if (sat < -64)
            sat = -64;
        d.left  = 10'((speed * lg) / 10);
        d.right = 10'((speed * rg) / 10);
        d.level = 7'(sat);
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Transfer monitor: predicts on input, checks on output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_check
        drive_t exp_d;
        if (rst_n)
        begin
            if (cfg_we)
                ref_mirror = cfg_data;
            if (out_valid && out_ready)
            begin
                if (drive_expq.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: L=%0d R=%0d lvl=%0d",
                                 left_drive, right_drive, correction_level);
                end
                else
                begin
                    exp_d = drive_expq.pop_front();
                    if (left_drive !== exp_d.left || right_drive !== exp_d.right ||
                        correction_level !== exp_d.level)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp L=%0d R=%0d lvl=%0d, got L=%0d R=%0d lvl=%0d",
                                     exp_d.left, exp_d.right, exp_d.level,
                                     left_drive, right_drive, correction_level);
                    end
                end
            end
            if (in_valid && in_ready)
                drive_expq.push_back(steer_predict(heading, base_speed, ref_mirror));
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        int idle_cnt;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt == IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                stall = gap_len();
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus helpers (called just after a rising edge)
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [15:0] hdg,
                               input logic signed [8:0]  spd);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        heading    <= hdg;
        base_speed <= spd;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering and let every expected result come back
    task automatic drain();
        in_valid <= 1'b0;
        // Let the monitor log the last input transfer before the queue is polled
        @(posedge clk);
        while (drive_expq.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_reference(input logic signed [16:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Heading pattern: full range, stated range, near target, near half turn
    function automatic logic signed [15:0] pick_heading();
        int tgt;
        int a;
        tgt = wrap_turn(int'(ref_mirror));
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 36000)) - hhds_pkg::HALF_TURN);
            2: a = tgt + int'($urandom_range(0, 6000)) - 3000;
            default: a = tgt + hhds_pkg::HALF_TURN + int'($urandom_range(0, 6)) - 3;
        endcase
        return 16'(wrap_turn(a) - hhds_pkg::HALF_TURN);
    endfunction

    function automatic logic signed [8:0] pick_speed();
        case ($urandom_range(0, 5))
            0: return 9'($urandom);
            1: return 9'sd0;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 9'sd255;
                    1: return -9'sd255;
                    2: return -9'sd256;
                    3: return 9'sd1;
                    default: return -9'sd1;
                endcase
            end
            default: return 9'(int'($urandom_range(0, 510)) - 255);
        endcase
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_sample(pick_heading(), pick_speed());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset target of zero: zero error, zero speed, half turn, level steps,
    // gain clamp, sign flips and truncation, field extremes
    task automatic test_directed();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send_sample(16'sd0,      9'sd100);
        send_sample(16'sd0,      9'sd0);
        send_sample(16'sd18000,  9'sd100);
        send_sample(-16'sd18000, 9'sd100);
        send_sample(16'sd18000,  -9'sd100);
        send_sample(16'sd17999,  9'sd200);
        send_sample(-16'sd17999, 9'sd200);
        send_sample(16'sd499,    9'sd100);
        send_sample(16'sd500,    9'sd100);
        send_sample(-16'sd1000,  9'sd100);
        send_sample(16'sd1500,   9'sd255);
        send_sample(16'sd2000,   9'sd255);
        send_sample(-16'sd2000,  -9'sd255);
        send_sample(16'sd32767,  9'sd255);
        send_sample(-16'sd32768, -9'sd256);
        send_sample(16'sd3000,   9'sd1);
        send_sample(16'sd3000,   -9'sd1);
        send_sample(-16'sd1500,  9'sd7);
        send_sample(-16'sd1500,  -9'sd7);
        send_sample(16'sd1,      -9'sd256);
        send_sample(-16'sd1,     9'sd255);
    endtask

    // Target register at its field extremes and at the wrap points
    task automatic test_reference_extremes();
        logic signed [16:0] refs[6];
        refs = '{-17'sd65536, 17'sd65535, -17'sd18000, 17'sd35999, 17'sd36000, -17'sd1};
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        foreach (refs[i])
        begin
            write_reference(refs[i]);
            send_random(40);
        end
    endtask

    // Random targets, random content, random idling on both sides
    task automatic test_random_sweep();
        repeat (7)
        begin
            if ($urandom_range(0, 1) == 0)
                write_reference(17'(int'($urandom_range(0, 53999)) - hhds_pkg::HALF_TURN));
            else
                write_reference(17'($urandom));
            tx_gap_pct   = $urandom_range(0, 50);
            rx_stall_pct = $urandom_range(0, 50);
            send_random(200);
        end
    endtask

    // Back-to-back with no idling on either side
    task automatic test_full_rate();
        write_reference(17'sd9000);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_random(200);
    endtask

    // Long output hold-off while the input keeps offering
    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        send_random(80);
        rx_stall_pct = 25;
        send_random(40);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        heading    <= '0;
        base_speed <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_reference_extremes();
        test_random_sweep();
        test_full_rate();
        test_backpressure();

        drain();
        if (drive_expq.size() != 0)
        begin
            fail_count++;
            $display("%0d expected results never arrived", drive_expq.size());
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### heading_hold_differential_steer_top.f
rtl/hhds_pkg.sv
rtl/hhds_err.sv
rtl/hhds_quant.sv
rtl/hhds_drive.sv
rtl/heading_hold_differential_steer_top.sv
tb/tb_top.sv
